// File: sv/slt_pkg.sv
package slt_pkg;

    // table geometry
    localparam int SEGMENT_COUNT_DEF   = 1024;
    localparam int BLOCKS_PER_SEGMENT  = 4096;
    localparam int STRIPES_PER_SEGMENT = 1024;

    // field widths
    localparam int CMD_W   = 4;
    localparam int SEG_W   = 10;
    localparam int VB_W    = 13;
    localparam int ST_W    = 11;
    localparam int PHASE_W = 2;
    localparam int REP_W   = 3;
    localparam int ERR_W   = 2;

    // commands
    localparam logic [CMD_W-1:0] CMD_INIT     = 4'd0;
    localparam logic [CMD_W-1:0] CMD_ADD      = 4'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE   = 4'd2;
    localparam logic [CMD_W-1:0] CMD_STRIPE   = 4'd3;
    localparam logic [CMD_W-1:0] CMD_NVRAM    = 4'd4;
    localparam logic [CMD_W-1:0] CMD_SEAL     = 4'd5;
    localparam logic [CMD_W-1:0] CMD_VICTIM   = 4'd6;
    localparam logic [CMD_W-1:0] CMD_VIC_FREE = 4'd7;
    localparam logic [CMD_W-1:0] CMD_QUERY    = 4'd8;

    // segment phases
    localparam logic [PHASE_W-1:0] PH_FREE   = 2'd0;
    localparam logic [PHASE_W-1:0] PH_NVRAM  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_SSD    = 2'd2;
    localparam logic [PHASE_W-1:0] PH_VICTIM = 2'd3;

    // reported phase for an error
    localparam logic [REP_W-1:0] REP_ERROR = 3'd4;

    // error codes
    localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
    localparam logic [ERR_W-1:0] ERR_UNDER = 2'd1;
    localparam logic [ERR_W-1:0] ERR_NVRAM = 2'd2;
    localparam logic [ERR_W-1:0] ERR_OVER  = 2'd3;

    // saturation values
    localparam logic [VB_W-1:0] VB_SAT = VB_W'(BLOCKS_PER_SEGMENT);
    localparam logic [ST_W-1:0] ST_SAT = ST_W'(STRIPES_PER_SEGMENT);

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [SEG_W-1:0] segment;
        logic [VB_W-1:0]  amount;
        logic             allow_victim_release;
    } t_req;

    typedef struct packed {
        logic             ok;
        logic [REP_W-1:0] reported_phase;
        logic [VB_W-1:0]  valid_blocks;
        logic [ST_W-1:0]  occupied_stripes;
        logic             in_ssd;
        logic [ERR_W-1:0] error;
    } t_result;

    // one table entry
    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [VB_W-1:0]    valid_blocks;
        logic [ST_W-1:0]    stripes;
    } t_entry;

endpackage

// File: sv/slt_mem.sv
module slt_mem
    import slt_pkg::*;
#(
    parameter int SEGMENT_COUNT = SEGMENT_COUNT_DEF,
    localparam int SEG_AW = (SEGMENT_COUNT > 1) ? $clog2(SEGMENT_COUNT) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [SEG_AW-1:0] i_rd_addr,
    input  logic              i_wr_en,
    input  logic [SEG_AW-1:0] i_wr_addr,
    input  t_entry            i_wr_data,
    output t_entry            o_rd_data,
    output logic              o_clearing
);

    t_entry            mem [SEGMENT_COUNT];
    t_entry            r_mem_q;
    t_entry            r_byp_data;
    logic              r_byp;
    logic              r_clearing;
    logic [SEG_AW-1:0] r_clr_idx;

    // clearing pass after reset, one entry per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clearing) begin
            if (r_clr_idx == SEG_AW'(SEGMENT_COUNT - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr_idx <= r_clr_idx + 1'b1;
        end
    end

    // write port
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            mem[r_clr_idx] <= '0;
        end else if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_mem_q <= mem[i_rd_addr];
        end
    end

    // bypass when the same entry is written in the cycle it is read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp <= 1'b0;
        end else begin
            r_byp <= i_rd_en && i_wr_en && (i_wr_addr == i_rd_addr);
        end
        r_byp_data <= i_wr_data;
    end

    assign o_rd_data  = r_byp ? r_byp_data : r_mem_q;
    assign o_clearing = r_clearing;

endmodule

// File: sv/slt_exec.sv
module slt_exec
    import slt_pkg::*;
(
    input  t_req    i_req,
    input  logic    i_in_range,
    input  t_entry  i_entry,
    output t_entry  o_entry,
    output t_result o_result
);

    t_entry             n_entry;
    logic               ok;
    logic               freed;
    logic [ERR_W-1:0]   err;
    logic [PHASE_W-1:0] prior;
    logic [VB_W-1:0]    v;
    logic [VB_W:0]      add_sum;
    logic [VB_W-1:0]    sub_val;
    logic [ST_W:0]      st_sum;
    logic [REP_W-1:0]   rep;

    // command decode and entry update
    always_comb begin
        prior   = i_entry.phase;
        v       = i_entry.valid_blocks;
        add_sum = {1'b0, v} + {1'b0, i_req.amount};
        sub_val = v - i_req.amount;
        st_sum  = {1'b0, i_entry.stripes} + (ST_W + 1)'(1);
        n_entry = i_entry;
        ok      = 1'b0;
        freed   = 1'b0;
        err     = ERR_NONE;
        unique case (i_req.command)
            CMD_INIT: begin
                n_entry = '0;
                ok      = 1'b1;
            end
            CMD_ADD: begin
                if (32'(add_sum) > 32'(BLOCKS_PER_SEGMENT)) begin
                    n_entry.valid_blocks = VB_SAT;
                    err                  = ERR_OVER;
                end else begin
                    n_entry.valid_blocks = add_sum[VB_W-1:0];
                    ok                   = 1'b1;
                end
            end
            CMD_REMOVE: begin
                if (i_req.amount > v) begin
                    err = ERR_UNDER;
                end else begin
                    n_entry.valid_blocks = sub_val;
                    if (sub_val == '0 && (prior == PH_SSD ||
                        (i_req.allow_victim_release && prior == PH_VICTIM))) begin
                        n_entry = '0;
                        freed   = 1'b1;
                        ok      = 1'b1;
                    end
                end
            end
            CMD_STRIPE: begin
                if (32'(st_sum) > 32'(STRIPES_PER_SEGMENT)) begin
                    n_entry.stripes = ST_SAT;
                    err             = ERR_OVER;
                end else begin
                    n_entry.stripes = st_sum[ST_W-1:0];
                    ok              = 1'b1;
                end
            end
            CMD_NVRAM: begin
                if (prior == PH_FREE) begin
                    n_entry.phase = PH_NVRAM;
                    ok            = 1'b1;
                end else begin
                    err = ERR_NVRAM;
                end
            end
            CMD_SEAL: begin
                if (v == '0) begin
                    n_entry = '0;
                    freed   = 1'b1;
                    ok      = 1'b1;
                end else begin
                    n_entry.phase = PH_SSD;
                end
            end
            CMD_VICTIM: begin
                if (prior == PH_SSD) begin
                    n_entry.phase = PH_VICTIM;
                    ok            = 1'b1;
                end
            end
            CMD_VIC_FREE: begin
                if (prior == PH_VICTIM && v == '0) begin
                    n_entry = '0;
                    freed   = 1'b1;
                    ok      = 1'b1;
                end
            end
            CMD_QUERY: begin
                ok = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // reported phase: error phase on underflow, prior phase when freed, current otherwise
    always_comb begin
        if (err == ERR_UNDER) begin
            rep = REP_ERROR;
        end else if (freed) begin
            rep = {1'b0, prior};
        end else begin
            rep = {1'b0, n_entry.phase};
        end
    end

    // result assembly, out-of-range segments answer with an error phase
    always_comb begin
        if (i_in_range) begin
            o_result.ok               = ok;
            o_result.reported_phase   = rep;
            o_result.valid_blocks     = n_entry.valid_blocks;
            o_result.occupied_stripes = n_entry.stripes;
            o_result.in_ssd           = (n_entry.phase == PH_SSD);
            o_result.error            = err;
        end else begin
            o_result                = '0;
            o_result.reported_phase = REP_ERROR;
        end
    end

    assign o_entry = n_entry;

endmodule

// File: sv/segment_lifecycle_table.sv
// Segment lifecycle table: keeps phase, valid-block count and stripe count for
// every segment in a single-port-write, registered-read memory. A command is
// taken when start is high and busy is low; its result appears on o_result
// with o_result_valid high for exactly one cycle: it passes through the execute
// and result registers and is not held back by the receiver. One command can
// be taken every cycle while busy is low: the memory read is issued on the
// accepting edge, the update is computed and written back on the next edge,
// and a command that reads the entry being written picks up the new value
// through a bypass. After reset the block clears the whole table, one entry
// per cycle, and keeps busy high until the pass is done; busy is low at all
// other times.
module segment_lifecycle_table
    import slt_pkg::*;
#(
    parameter int SEGMENT_COUNT = SEGMENT_COUNT_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_req    i_req,
    output logic    o_result_valid,
    output t_result o_result
);

    localparam int SEG_AW = (SEGMENT_COUNT > 1) ? $clog2(SEGMENT_COUNT) : 1;

    logic              accept;
    logic              clearing;
    logic [31:0]       seg_ext;
    logic [SEG_AW-1:0] rd_addr;
    logic              in_range;
    t_entry            rd_data;
    t_entry            wr_data;
    t_result           ex_result;
    logic              wr_en;

    logic              r_ex_valid;
    t_req              r_ex_req;
    logic              r_ex_in_range;
    logic [SEG_AW-1:0] r_ex_addr;
    logic              r_res_valid;
    t_result           r_res;

    // address and range check
    assign accept   = start && !clearing;
    assign seg_ext  = 32'(i_req.segment);
    assign rd_addr  = seg_ext[SEG_AW-1:0];
    assign in_range = seg_ext < 32'(SEGMENT_COUNT);
    assign wr_en    = r_ex_valid && r_ex_in_range;

    slt_mem #(
        .SEGMENT_COUNT(SEGMENT_COUNT)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept && in_range),
        .i_rd_addr (rd_addr),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_ex_addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data),
        .o_clearing(clearing)
    );

    slt_exec u_exec (
        .i_req     (r_ex_req),
        .i_in_range(r_ex_in_range),
        .i_entry   (rd_data),
        .o_entry   (wr_data),
        .o_result  (ex_result)
    );

    // execute stage, aligned with the memory read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ex_valid <= 1'b0;
        end else begin
            r_ex_valid <= accept;
        end
        if (accept) begin
            r_ex_req      <= i_req;
            r_ex_in_range <= in_range;
            r_ex_addr     <= rd_addr;
        end
    end

    // result register, one-cycle strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= r_ex_valid;
        end
        if (r_ex_valid) begin
            r_res <= ex_result;
        end
    end

    assign busy           = clearing;
    assign o_result_valid = r_res_valid;
    assign o_result       = r_res;

endmodule

// File: sv/slt_checker.sv
module slt_checker
    import slt_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    start,
    input logic    busy,
    input logic    o_result_valid,
    input t_result o_result
);

    // reset always starts the clearing pass
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("busy not raised after reset");

    // every accepted transaction yields a result after the execute and result registers
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_result_valid)
        else $error("result strobe missing after accepted transaction");

    // no result without an accepted transaction
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(start && !busy, 2))
        else $error("result strobe without accepted transaction");

    // underflow reports the error phase and never succeeds
    a_underflow_rep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.error == ERR_UNDER) |->
            (o_result.reported_phase == REP_ERROR && !o_result.ok))
        else $error("underflow result malformed");

    // a flagged error never comes with success
    a_err_not_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.error != ERR_NONE) |-> !o_result.ok)
        else $error("error flagged on successful command");

endmodule

bind segment_lifecycle_table slt_checker u_slt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_result_valid(o_result_valid),
    .o_result      (o_result)
);
